// ===== src/isbr_pkg.sv =====
// Shared types, constants and sample-unpacking helpers for the I2C sensor burst reader.
// Used by every module of the block except the generic RAM; has no dependencies of its own.
`default_nettype none

package isbr_pkg;

    localparam int FRAME_LENGTH = 23;
    localparam int FRAME_AW     = $clog2(FRAME_LENGTH);
    localparam int COUNT_W      = 5;
    localparam int NUM_SAMPLES  = 11;
    localparam int SAMPLE_IW    = 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;

    localparam logic [6:0] DEFAULT_DEV_ADDR  = 7'b1101001;
    localparam logic [7:0] DEFAULT_START_REG = 8'd45;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_REGISTER = 1'b1;

    localparam logic [COUNT_W-1:0] LAST_BYTE_COUNT = COUNT_W'(FRAME_LENGTH - 1);
    localparam logic [SAMPLE_IW-1:0] LAST_SAMPLE   = SAMPLE_IW'(NUM_SAMPLES - 1);

    // Sample layout inside the frame.
    localparam logic [SAMPLE_IW-1:0] FIRST_MAG_SAMPLE = 4'd7;
    localparam logic [SAMPLE_IW-1:0] STATUS_SAMPLE    = 4'd10;
    localparam logic [FRAME_AW-1:0]  MAG_LO_BASE      = FRAME_AW'(15);
    localparam logic [FRAME_AW-1:0]  MAG_HI_BASE      = FRAME_AW'(16);
    localparam logic [FRAME_AW-1:0]  STATUS_HI_BYTE   = FRAME_AW'(14);
    localparam logic [FRAME_AW-1:0]  STATUS_LO_BYTE   = FRAME_AW'(22);
    localparam logic [7:0]           STATUS_HI_MASK   = 8'h03;
    localparam logic [7:0]           STATUS_LO_MASK   = 8'h04;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_TX      = 3'd1,
        ACT_RESTART = 3'd2,
        ACT_RX      = 3'd3,
        ACT_ACK     = 3'd4,
        ACT_STOP    = 3'd5,
        ACT_SAMPLE  = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        PH_ADDR_WR    = 3'd0,
        PH_REG        = 3'd1,
        PH_RESTART    = 3'd2,
        PH_ADDR_RD    = 3'd3,
        PH_RECV       = 3'd4,
        PH_ACK        = 3'd5,
        PH_FRAME_DONE = 3'd6,
        PH_IDLE       = 3'd7
    } t_phase;

    typedef struct packed {
        logic       ack_status;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        t_action              bus_action;
        logic [7:0]           tx_byte;
        logic                 ack_value;
        logic                 data_ready;
        logic                 error_flag;
        logic [SAMPLE_IW-1:0] sample_index;
        logic [15:0]          sample_value;
        logic                 last_result;
    } t_out;

    // One queued command from the front end. A burst command stands for the
    // stop plus all samples of a completed frame.
    typedef struct packed {
        t_action    action;
        logic [7:0] tx_byte;
        logic       ack_value;
        logic       data_ready;
        logic       error_flag;
        logic       burst;
    } t_cmd;

    typedef struct packed {
        logic [FRAME_AW-1:0] hi;
        logic [FRAME_AW-1:0] lo;
    } t_byte_pair;

    // Frame byte addresses that make up a given sample.
    function automatic t_byte_pair sample_addr(input logic [SAMPLE_IW-1:0] idx);
        t_byte_pair           p;
        logic [SAMPLE_IW-1:0] m;
        m = idx - FIRST_MAG_SAMPLE;
        if (idx < FIRST_MAG_SAMPLE) begin
            p.hi = FRAME_AW'({idx, 1'b0});
            p.lo = FRAME_AW'({idx, 1'b1});
        end else if (idx < STATUS_SAMPLE) begin
            // Magnetometer words are little-endian.
            p.hi = MAG_HI_BASE + FRAME_AW'({m, 1'b0});
            p.lo = MAG_LO_BASE + FRAME_AW'({m, 1'b0});
        end else begin
            p.hi = STATUS_HI_BYTE;
            p.lo = STATUS_LO_BYTE;
        end
        return p;
    endfunction

    function automatic logic [15:0] sample_word(input logic [SAMPLE_IW-1:0] idx,
                                                input logic [7:0] hi,
                                                input logic [7:0] lo);
        logic [15:0] w;
        if (idx == STATUS_SAMPLE) begin
            w = {hi & STATUS_HI_MASK, lo & STATUS_LO_MASK};
        end else begin
            w = {hi, lo};
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/isbr_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// Stands alone; holds the received frame bytes of the burst reader.
`default_nettype none

module isbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== src/isbr_front.sv =====
// Front end of the burst reader: accepts bus events, runs the transaction phases,
// stores frame bytes and queues one command per event. Depends on isbr_pkg.
`default_nettype none

module isbr_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [isbr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [isbr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire isbr_pkg::t_in                  i_item,
    input  wire logic                           i_queue_full,
    output logic                                o_push,
    output isbr_pkg::t_cmd                      o_cmd,
    output logic                                o_ram_we,
    output logic [isbr_pkg::FRAME_AW-1:0]       o_ram_waddr,
    output logic [7:0]                          o_ram_wdata,
    input  wire logic                           i_burst_done
);
    import isbr_pkg::*;

    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_ready_flag, n_ready_flag;
    logic               r_nack_error, n_nack_error;
    logic               r_hold, n_hold;
    logic [6:0]         r_dev_addr;
    logic [7:0]         r_start_reg;
    logic               fire;
    logic               last_byte;
    logic               addr_nack;

    // A new frame may not overwrite bytes whose samples are still waiting.
    assign o_ready   = !i_queue_full && !(r_phase == PH_ACK && r_hold);
    assign fire      = i_valid && o_ready;
    assign last_byte = (r_count == LAST_BYTE_COUNT);
    assign addr_nack = i_item.ack_status;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_ADDR_WR:    n_phase = PH_REG;
            PH_REG:        n_phase = addr_nack ? PH_IDLE : PH_RESTART;
            PH_RESTART:    n_phase = addr_nack ? PH_IDLE : PH_ADDR_RD;
            PH_ADDR_RD:    n_phase = PH_RECV;
            PH_RECV: begin
                n_phase = (r_count == '0 && addr_nack) ? PH_IDLE : PH_ACK;
            end
            PH_ACK:        n_phase = last_byte ? PH_FRAME_DONE : PH_RECV;
            PH_FRAME_DONE: n_phase = PH_IDLE;
            PH_IDLE:       n_phase = PH_ADDR_WR;
            default:       n_phase = PH_ADDR_WR;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_ready_flag = r_ready_flag;
        n_nack_error = r_nack_error;
        o_ram_we     = 1'b0;
        o_cmd        = '0;
        o_cmd.action = ACT_NONE;
        unique case (r_phase)
            PH_ADDR_WR: begin
                n_ready_flag  = 1'b0;
                n_nack_error  = 1'b0;
                o_cmd.action  = ACT_TX;
                o_cmd.tx_byte = {r_dev_addr, 1'b0};
            end
            PH_REG: begin
                if (addr_nack) begin
                    n_nack_error = 1'b1;
                    o_cmd.action = ACT_STOP;
                end else begin
                    o_cmd.action  = ACT_TX;
                    o_cmd.tx_byte = r_start_reg;
                end
            end
            PH_RESTART: begin
                if (addr_nack) begin
                    n_nack_error = 1'b1;
                    o_cmd.action = ACT_STOP;
                end else begin
                    o_cmd.action = ACT_RESTART;
                end
            end
            PH_ADDR_RD: begin
                n_count       = '0;
                o_cmd.action  = ACT_TX;
                o_cmd.tx_byte = {r_dev_addr, 1'b1};
            end
            PH_RECV: begin
                if (r_count == '0 && addr_nack) begin
                    n_nack_error = 1'b1;
                    o_cmd.action = ACT_STOP;
                end else begin
                    o_cmd.action = ACT_RX;
                end
            end
            PH_ACK: begin
                o_ram_we        = fire && (32'(r_count) < FRAME_LENGTH);
                n_count         = r_count + 1'b1;
                o_cmd.action    = ACT_ACK;
                o_cmd.ack_value = last_byte;
            end
            PH_FRAME_DONE: begin
                n_ready_flag = 1'b1;
                o_cmd.action = ACT_STOP;
                o_cmd.burst  = 1'b1;
            end
            PH_IDLE: begin
                o_cmd.action = ACT_NONE;
            end
            default: begin
                o_cmd.action = ACT_NONE;
            end
        endcase
        o_cmd.data_ready = n_ready_flag;
        o_cmd.error_flag = n_nack_error;
    end

    assign o_push      = fire;
    assign o_ram_waddr = r_count[FRAME_AW-1:0];
    assign o_ram_wdata = i_item.rx_byte;

    always_comb begin
        n_hold = r_hold;
        if (fire && r_phase == PH_FRAME_DONE) begin
            n_hold = 1'b1;
        end else if (i_burst_done) begin
            n_hold = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_ADDR_WR;
            r_count      <= '0;
            r_ready_flag <= 1'b0;
            r_nack_error <= 1'b0;
            r_hold       <= 1'b0;
            r_dev_addr   <= DEFAULT_DEV_ADDR;
            r_start_reg  <= DEFAULT_START_REG;
        end else begin
            r_hold <= n_hold;
            if (fire) begin
                r_phase      <= n_phase;
                r_count      <= n_count;
                r_ready_flag <= n_ready_flag;
                r_nack_error <= n_nack_error;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DEVICE_ADDRESS: r_dev_addr  <= i_cfg_data[6:0];
                    CFG_START_REGISTER: r_start_reg <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/isbr_queue.sv =====
// Short command queue between the front end and the result sequencer.
// Depends on isbr_pkg for the command type and depth.
`default_nettype none

module isbr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire isbr_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output isbr_pkg::t_cmd      o_cmd
);
    import isbr_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/isbr_back.sv =====
// Result sequencer: drains queued commands into the output register and expands a
// completed frame into stop plus eleven samples read from the frame RAM. Uses isbr_pkg.
`default_nettype none

module isbr_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_valid,
    input  wire isbr_pkg::t_cmd           i_q_cmd,
    output logic                          o_pop,
    output logic [isbr_pkg::FRAME_AW-1:0] o_raddr_hi,
    output logic [isbr_pkg::FRAME_AW-1:0] o_raddr_lo,
    input  wire logic [7:0]               i_rdata_hi,
    input  wire logic [7:0]               i_rdata_lo,
    output logic                          o_burst_done,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output isbr_pkg::t_out                o_item
);
    import isbr_pkg::*;

    logic                 r_busy, n_busy;
    logic [SAMPLE_IW-1:0] r_step, n_step;
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out, n_out;
    logic                 r_ready_flag, n_ready_flag;
    logic                 r_error_flag, n_error_flag;
    logic                 out_free;
    t_byte_pair           rd_pair;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_busy       = r_busy;
        n_step       = r_step;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_ready;
        n_ready_flag = r_ready_flag;
        n_error_flag = r_error_flag;
        o_pop        = 1'b0;
        o_burst_done = 1'b0;
        if (r_busy) begin
            if (out_free) begin
                // RAM data was fetched for r_step on the previous edge.
                n_out_valid        = 1'b1;
                n_out              = '0;
                n_out.bus_action   = ACT_SAMPLE;
                n_out.data_ready   = r_ready_flag;
                n_out.error_flag   = r_error_flag;
                n_out.sample_index = r_step;
                n_out.sample_value = sample_word(r_step, i_rdata_hi, i_rdata_lo);
                n_out.last_result  = (r_step == LAST_SAMPLE);
                if (r_step == LAST_SAMPLE) begin
                    n_busy       = 1'b0;
                    o_burst_done = 1'b1;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
        end else if (i_q_valid && out_free) begin
            o_pop             = 1'b1;
            n_out_valid       = 1'b1;
            n_out             = '0;
            n_out.bus_action  = i_q_cmd.action;
            n_out.tx_byte     = i_q_cmd.tx_byte;
            n_out.ack_value   = i_q_cmd.ack_value;
            n_out.data_ready  = i_q_cmd.data_ready;
            n_out.error_flag  = i_q_cmd.error_flag;
            n_out.last_result = !i_q_cmd.burst;
            if (i_q_cmd.burst) begin
                n_busy       = 1'b1;
                n_step       = '0;
                n_ready_flag = i_q_cmd.data_ready;
                n_error_flag = i_q_cmd.error_flag;
            end
        end
    end

    // Address follows the step that will be current next cycle, so the
    // registered read data lines up with r_step and holds during a stall.
    assign rd_pair    = sample_addr(n_step);
    assign o_raddr_hi = rd_pair.hi;
    assign o_raddr_lo = rd_pair.lo;

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_ready_flag <= n_ready_flag;
        r_error_flag <= n_error_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== src/i2c_sensor_burst_reader_core.sv =====
// Top level of the I2C sensor burst reader: front end, command queue, result
// sequencer and frame RAM. Depends on isbr_pkg and the isbr_* modules.
//
// Each accepted bus event produces one result, except the event that completes
// a frame, which produces a stop followed by eleven samples. Results leave
// through a registered output at one per cycle while the output is ready;
// events are accepted one per cycle as long as the four-entry command queue
// has room. The sample readout uses both read ports of the frame RAM each
// cycle. A received data byte is held off while the previous frame's samples
// are still being read out.
`default_nettype none

module i2c_sensor_burst_reader_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [isbr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [isbr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire isbr_pkg::t_in                   i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output isbr_pkg::t_out                       o_out_item
);
    import isbr_pkg::*;

    logic                queue_full;
    logic                push;
    t_cmd                push_cmd;
    logic                pop;
    logic                q_valid;
    t_cmd                q_cmd;
    logic                ram_we;
    logic [FRAME_AW-1:0] ram_waddr;
    logic [7:0]          ram_wdata;
    logic [FRAME_AW-1:0] raddr_hi;
    logic [FRAME_AW-1:0] raddr_lo;
    logic [7:0]          rdata_hi;
    logic [7:0]          rdata_lo;
    logic                burst_done;

    isbr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (i_in_item),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .i_burst_done (burst_done)
    );

    isbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    isbr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_LENGTH)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (raddr_hi),
        .i_raddr_b (raddr_lo),
        .o_rdata_a (rdata_hi),
        .o_rdata_b (rdata_lo)
    );

    isbr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_pop        (pop),
        .o_raddr_hi   (raddr_hi),
        .o_raddr_lo   (raddr_lo),
        .i_rdata_hi   (rdata_hi),
        .i_rdata_lo   (rdata_lo),
        .o_burst_done (burst_done),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_item       (o_out_item)
    );

endmodule

`default_nettype wire

// ===== dv/tb_i2c_sensor_burst_reader_core.sv =====
// Self-checking testbench for i2c_sensor_burst_reader_core: a directed table of bus events,
// then random event sequences under four register settings, checked against a local model.
// Depends on isbr_pkg and the RTL of the block only.
module tb_i2c_sensor_burst_reader_core;
    import isbr_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SEGMENT_EVENTS = 80;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        t_in  ev;
        logic typed;
        t_out want;
    } t_stim_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in_item   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out                  o_out_item;

    // Local copy of the sequencer state and its registers.
    t_phase       rd_phase;
    logic [4:0]   rd_count;
    logic [7:0]   frame_mem [FRAME_LENGTH];
    logic         rd_ready;
    logic         rd_err;
    logic [6:0]   cfg_dev_addr;
    logic [7:0]   cfg_start_reg;

    t_out         expected_results [$];
    t_stim_row    stim_tab [$];
    t_out         want_item;
    int           fail_count = 0;
    int           cycle_count = 0;
    int           hold_left = 0;
    bit           hold_arm = 1'b0;
    bit           no_idle = 1'b0;

    i2c_sensor_burst_reader_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_out mk_result(input t_action act, input logic [7:0] tx,
                                       input logic ackv, input logic rdy, input logic err);
        t_out r;
        r              = '0;
        r.bus_action   = act;
        r.tx_byte      = tx;
        r.ack_value    = ackv;
        r.data_ready   = rdy;
        r.error_flag   = err;
        r.last_result  = 1'b1;
        return r;
    endfunction

    function automatic string describe_result(input t_out r);
        return $sformatf("act=%0d tx=%02h ack=%0d rdy=%0d err=%0d idx=%0d val=%04h last=%0d",
                         r.bus_action, r.tx_byte, r.ack_value, r.data_ready, r.error_flag,
                         r.sample_index, r.sample_value, r.last_result);
    endfunction

    // Advances the local sequencer by one bus event and queues the results it causes.
    task automatic predict_bus_event(input t_in ev);
        t_out r;
        logic last_byte;
        int   m;
        case (rd_phase)
            PH_ADDR_WR: begin
                rd_ready = 1'b0;
                rd_err   = 1'b0;
                expected_results.push_back(mk_result(ACT_TX, {cfg_dev_addr, 1'b0}, 1'b0,
                                                     rd_ready, rd_err));
                rd_phase = PH_REG;
            end
            PH_REG, PH_RESTART: begin
                if (ev.ack_status) begin
                    rd_err = 1'b1;
                    expected_results.push_back(mk_result(ACT_STOP, 8'h00, 1'b0,
                                                         rd_ready, rd_err));
                    rd_phase = PH_IDLE;
                end else if (rd_phase == PH_REG) begin
                    expected_results.push_back(mk_result(ACT_TX, cfg_start_reg, 1'b0,
                                                         rd_ready, rd_err));
                    rd_phase = PH_RESTART;
                end else begin
                    expected_results.push_back(mk_result(ACT_RESTART, 8'h00, 1'b0,
                                                         rd_ready, rd_err));
                    rd_phase = PH_ADDR_RD;
                end
            end
            PH_ADDR_RD: begin
                rd_count = '0;
                expected_results.push_back(mk_result(ACT_TX, {cfg_dev_addr, 1'b1}, 1'b0,
                                                     rd_ready, rd_err));
                rd_phase = PH_RECV;
            end
            PH_RECV: begin
                // A nack only aborts before the first data byte.
                if (rd_count == 0 && ev.ack_status) begin
                    rd_err = 1'b1;
                    expected_results.push_back(mk_result(ACT_STOP, 8'h00, 1'b0,
                                                         rd_ready, rd_err));
                    rd_phase = PH_IDLE;
                end else begin
                    expected_results.push_back(mk_result(ACT_RX, 8'h00, 1'b0,
                                                         rd_ready, rd_err));
                    rd_phase = PH_ACK;
                end
            end
            PH_ACK: begin
                last_byte = (rd_count == FRAME_LENGTH - 1);
                frame_mem[rd_count] = ev.rx_byte;
                rd_count = rd_count + 5'd1;
                expected_results.push_back(mk_result(ACT_ACK, 8'h00, last_byte,
                                                     rd_ready, rd_err));
                rd_phase = last_byte ? PH_FRAME_DONE : PH_RECV;
            end
            PH_FRAME_DONE: begin
                rd_ready = 1'b1;
                r = mk_result(ACT_STOP, 8'h00, 1'b0, rd_ready, rd_err);
                r.last_result = 1'b0;
                expected_results.push_back(r);
                for (int s = 0; s < NUM_SAMPLES; s++) begin
                    r = mk_result(ACT_SAMPLE, 8'h00, 1'b0, rd_ready, rd_err);
                    r.sample_index = SAMPLE_IW'(s);
                    if (s < 7) begin
                        r.sample_value = {frame_mem[2 * s], frame_mem[2 * s + 1]};
                    end else if (s < 10) begin
                        // Magnetometer words arrive low byte first.
                        m = s - 7;
                        r.sample_value = {frame_mem[16 + 2 * m], frame_mem[15 + 2 * m]};
                    end else begin
                        r.sample_value = {6'd0, frame_mem[14][1:0], frame_mem[22] & 8'h04};
                    end
                    r.last_result = (s == NUM_SAMPLES - 1);
                    expected_results.push_back(r);
                end
                rd_phase = PH_IDLE;
            end
            default: begin
                expected_results.push_back(mk_result(ACT_NONE, 8'h00, 1'b0,
                                                     rd_ready, rd_err));
                rd_phase = PH_ADDR_WR;
            end
        endcase
    endtask

    // Nacks where they abort are rare so that frames complete; elsewhere the ack bit is random.
    function automatic t_in pick_bus_event();
        t_in ev;
        int  pick;
        if (rd_phase == PH_REG || rd_phase == PH_RESTART ||
            (rd_phase == PH_RECV && rd_count == 0)) begin
            ev.ack_status = ($urandom_range(99) < 6);
        end else begin
            ev.ack_status = 1'($urandom_range(1));
        end
        pick = $urandom_range(7);
        if (pick == 0) begin
            ev.rx_byte = 8'h00;
        end else if (pick == 1) begin
            ev.rx_byte = 8'hFF;
        end else begin
            ev.rx_byte = 8'($urandom_range(255));
        end
        return ev;
    endfunction

    task automatic add_row(input logic nack, input logic [7:0] rx_v, input logic typed,
                           input t_action act, input logic [7:0] tx, input logic ackv,
                           input logic err);
        t_stim_row row;
        row.ev.ack_status = nack;
        row.ev.rx_byte    = rx_v;
        row.typed         = typed;
        row.want          = mk_result(act, tx, ackv, 1'b0, err);
        stim_tab.push_back(row);
    endtask

    // Offers one item and returns at the edge where it is accepted.
    task automatic offer_event(input t_in ev, input logic typed, input t_out want);
        while (!no_idle && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= ev;
        do @(posedge i_clk); while (!o_in_ready);
        predict_bus_event(ev);
        if (typed) begin
            expected_results[expected_results.size() - 1] = want;
        end
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_registers(input logic [7:0] dev_data, input logic [7:0] reg_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DEVICE_ADDRESS;
        i_cfg_data  <= dev_data;
        @(posedge i_clk);
        i_cfg_index <= CFG_START_REGISTER;
        i_cfg_data  <= reg_data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_dev_addr  = dev_data[6:0];
        cfg_start_reg = reg_data;
    endtask

    // Output side: random back-pressure, one long hold-off, and the result check.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result: %s", describe_result(o_out_item));
                end
                fail_count++;
            end else begin
                want_item = expected_results.pop_front();
                if (o_out_item !== want_item) begin
                    if (fail_count < 10) begin
                        $display("mismatch: expected %s", describe_result(want_item));
                        $display("          actual   %s", describe_result(o_out_item));
                    end
                    fail_count++;
                end
            end
        end
        if (hold_arm) begin
            hold_arm  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(99) >= 17);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[i2c_sensor_burst_reader_core] ERROR");
            $finish;
        end
    end

    initial begin
        rd_phase      = PH_ADDR_WR;
        rd_count      = '0;
        rd_ready      = 1'b0;
        rd_err        = 1'b0;
        cfg_dev_addr  = DEFAULT_DEV_ADDR;
        cfg_start_reg = DEFAULT_START_REG;

        // Nack on the register byte, nack on the restart, nack on the read address,
        // ignored ack bits, then the start of a frame with extreme data bytes.
        add_row(1'b0, 8'h00, 1'b1, ACT_TX,      8'hD2, 1'b0, 1'b0);
        add_row(1'b1, 8'hFF, 1'b1, ACT_STOP,    8'h00, 1'b0, 1'b1);
        add_row(1'b0, 8'h00, 1'b1, ACT_NONE,    8'h00, 1'b0, 1'b1);
        add_row(1'b1, 8'h00, 1'b1, ACT_TX,      8'hD2, 1'b0, 1'b0);
        add_row(1'b0, 8'hFF, 1'b1, ACT_TX,      8'h2D, 1'b0, 1'b0);
        add_row(1'b1, 8'hA5, 1'b1, ACT_STOP,    8'h00, 1'b0, 1'b1);
        add_row(1'b1, 8'h5A, 1'b1, ACT_NONE,    8'h00, 1'b0, 1'b1);
        add_row(1'b0, 8'h00, 1'b1, ACT_TX,      8'hD2, 1'b0, 1'b0);
        add_row(1'b0, 8'h00, 1'b1, ACT_TX,      8'h2D, 1'b0, 1'b0);
        add_row(1'b0, 8'h00, 1'b1, ACT_RESTART, 8'h00, 1'b0, 1'b0);
        add_row(1'b1, 8'hFF, 1'b1, ACT_TX,      8'hD3, 1'b0, 1'b0);
        add_row(1'b1, 8'h00, 1'b1, ACT_STOP,    8'h00, 1'b0, 1'b1);
        add_row(1'b0, 8'h00, 1'b1, ACT_NONE,    8'h00, 1'b0, 1'b1);
        add_row(1'b0, 8'hFF, 1'b1, ACT_TX,      8'hD2, 1'b0, 1'b0);
        add_row(1'b0, 8'h00, 1'b1, ACT_TX,      8'h2D, 1'b0, 1'b0);
        add_row(1'b0, 8'h00, 1'b1, ACT_RESTART, 8'h00, 1'b0, 1'b0);
        add_row(1'b0, 8'h00, 1'b1, ACT_TX,      8'hD3, 1'b0, 1'b0);
        add_row(1'b0, 8'h00, 1'b1, ACT_RX,      8'h00, 1'b0, 1'b0);
        add_row(1'b1, 8'hFF, 1'b1, ACT_ACK,     8'h00, 1'b0, 1'b0);
        add_row(1'b1, 8'h00, 1'b1, ACT_RX,      8'h00, 1'b0, 1'b0);
        add_row(1'b0, 8'h00, 1'b1, ACT_ACK,     8'h00, 1'b0, 1'b0);
        add_row(1'b0, 8'h80, 1'b0, ACT_NONE,    8'h00, 1'b0, 1'b0);
        add_row(1'b1, 8'h7F, 1'b0, ACT_NONE,    8'h00, 1'b0, 1'b0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_tab[k]) begin
            offer_event(stim_tab[k].ev, stim_tab[k].typed, stim_tab[k].want);
        end

        for (int seg = 0; seg < 4; seg++) begin
            i_in_valid <= 1'b0;
            wait_drained();
            case (seg)
                0:       write_registers(8'hFF, 8'hFF);
                1:       write_registers(8'h00, 8'h00);
                default: write_registers(8'($urandom_range(255)), 8'($urandom_range(255)));
            endcase
            no_idle = (seg == 1);
            // The hold-off fills the command queue while items keep coming.
            if (seg == 2) begin
                hold_arm = 1'b1;
            end
            for (int k = 0; k < SEGMENT_EVENTS; k++) begin
                offer_event(pick_bus_event(), 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("[i2c_sensor_burst_reader_core] OK");
        end else begin
            $display("[i2c_sensor_burst_reader_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/isbr_pkg.sv
src/isbr_ram.sv
src/isbr_front.sv
src/isbr_queue.sv
src/isbr_back.sv
src/i2c_sensor_burst_reader_core.sv
dv/tb_i2c_sensor_burst_reader_core.sv
